// ===== src/vcp_pkg.sv =====
package vcp_pkg;

    // Bus operation carried in the kind field of an input item
    typedef enum logic [2:0] {
        OP_CTRL_WR   = 3'd0,
        OP_DATA_WR   = 3'd1,
        OP_STATUS_RD = 3'd2,
        OP_DATA_RD   = 3'd3,
        OP_FRAME_IRQ = 3'd4,
        OP_LINE_IRQ  = 3'd5
    } bus_op_t;

    // Access modes loaded by an address command
    localparam logic [1:0] ACC_VRAM_RD = 2'd0;
    localparam logic [1:0] ACC_CRAM    = 2'd3;

    // Top nibble of a command that loads a display register
    localparam logic [3:0] REG_CMD_TAG   = 4'h8;
    localparam logic [3:0] NUM_DISP_REGS = 4'd11;

    localparam int ADDR_W  = 14;
    localparam int CRAM_AW = 5;

    typedef struct packed {
        logic               rd_en;
        logic [CRAM_AW-1:0] rd_idx;
        logic               wr_en;
        logic [CRAM_AW-1:0] wr_idx;
        logic [7:0]         wr_data;
    } cram_req_t;

endpackage

// ===== src/vcp_cram.sv =====
module vcp_cram
    import vcp_pkg::*;
#(
    parameter int CRAM_ENTRIES = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cram_req_t  req,
    output logic [7:0] rd_data
);

    localparam int CI_W = $clog2(CRAM_ENTRIES);

    logic [7:0]              cram_mem [CRAM_ENTRIES];
    logic [CRAM_ENTRIES-1:0] valid_reg;
    logic [7:0]              rdata_reg;
    logic                    rvalid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            cram_mem[req.wr_idx[CI_W-1:0]] <= req.wr_data;
        end
        if (req.rd_en) begin
            rdata_reg <= cram_mem[req.rd_idx[CI_W-1:0]];
        end
    end

    // an entry never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_idx[CI_W-1:0]] <= 1'b1;
            end
            if (req.rd_en) begin
                rvalid_reg <= valid_reg[req.rd_idx[CI_W-1:0]];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : 8'd0;

endmodule

// ===== src/vcp_vram.sv =====
module vcp_vram #(
    parameter int VRAM_BANKS = 2,
    parameter int BANK_BYTES = 16384
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       rd_en,
    input  logic [$clog2(VRAM_BANKS*BANK_BYTES)-1:0]   rd_idx,
    input  logic                                       wr_en,
    input  logic [$clog2(VRAM_BANKS*BANK_BYTES)-1:0]   wr_idx,
    input  logic [7:0]                                 wr_data,
    output logic [7:0]                                 rd_data,
    output logic                                       busy
);

    localparam int DEPTH = VRAM_BANKS * BANK_BYTES;
    localparam int VA_W  = $clog2(DEPTH);

    logic [7:0]      vram_mem [DEPTH];
    logic [7:0]      rdata_reg;
    logic            busy_reg;
    logic [VA_W-1:0] clr_cnt_reg;

    // zero sweep after reset, one entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (busy_reg) begin
            if (clr_cnt_reg == VA_W'(DEPTH - 1)) begin
                busy_reg <= 1'b0;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            vram_mem[clr_cnt_reg] <= 8'd0;
        end else if (wr_en) begin
            vram_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= vram_mem[rd_idx];
        end
    end

    assign rd_data = rdata_reg;
    assign busy    = busy_reg;

endmodule

// ===== src/video_chip_port_interface.sv =====
// channel | ports                          | content
// input   | s_tvalid s_tready s_tdata s_tuser | one bus access or interrupt event
// result  | m_tvalid m_tready m_tdata m_tuser | one result per input item
// config  | cfg_valid cfg_ready cfg_data   | video memory bank select
//
// Each item is accepted with its memory read issued, then updated and written back.
// No new item is accepted until the previous one has finished its update.
// After reset the video memory is zeroed; no item is accepted meanwhile,
// configuration writes are.
// A result waiting on m_tready does not block acceptance; a second item stalls in
// its update cycle until the result register frees up.
module video_chip_port_interface
    import vcp_pkg::*;
#(
    parameter int VRAM_BANKS   = 2,
    parameter int BANK_BYTES   = 16384,
    parameter int CRAM_ENTRIES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_tuser,   // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [12:8] palette_index, [18:13] palette_colour,
    // [22:19] register_index, [30:23] register_value, [31] zero
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser,   // [0] palette_changed, [1] register_written
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam int VA_W = $clog2(VRAM_BANKS * BANK_BYTES);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t              state_reg;
    logic                bank_reg;
    logic                pending_reg, pending_next;
    logic [7:0]          low_reg, low_next;
    logic [1:0]          acc_mode_reg, acc_mode_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [7:0]          rbuf_reg, rbuf_next;
    logic                frame_reg, frame_next;
    logic                line_reg, line_next;
    bus_op_t             op_reg;
    logic [7:0]          byte_reg;
    logic                m_valid_reg;
    logic [31:0]         m_data_reg;
    logic [1:0]          m_user_reg;

    logic [7:0]          res_read;
    logic                res_pal_chg;
    logic [CRAM_AW-1:0]  res_pal_idx;
    logic [5:0]          res_pal_col;
    logic                res_reg_wr;
    logic [3:0]          res_reg_idx;
    logic [7:0]          res_reg_val;

    bus_op_t             in_op;
    logic                accept, exec_go, out_free;
    logic                cmd_vram_rd, dat_vram_rd;
    logic [ADDR_W-1:0]   rd_addr;
    logic                vram_rd_en, vram_wr_en, vram_busy;
    logic [VA_W-1:0]     vram_rd_idx, vram_wr_idx;
    logic [7:0]          vram_rdata, cram_rdata;
    logic [CRAM_AW-1:0]  cram_idx;
    cram_req_t           cram_req;
    logic [ADDR_W-1:0]   cmd_addr;

    // bank and offset within the bank, folded into one memory index
    function automatic logic [VA_W-1:0] vram_index(input logic bank,
                                                    input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] off;
        logic [16:0]       sum;
        off = addr;
        for (int i = 0; i < 3; i++) begin
            if ({1'b0, off} >= (ADDR_W + 1)'(BANK_BYTES)) begin
                off = off - ADDR_W'(BANK_BYTES);
            end
        end
        sum = {3'd0, off} + ((bank && (VRAM_BANKS > 1)) ? 17'(BANK_BYTES) : 17'd0);
        return sum[VA_W-1:0];
    endfunction

    function automatic logic [CRAM_AW-1:0] cram_index(input logic [CRAM_AW-1:0] a);
        logic [CRAM_AW-1:0] idx;
        idx = a;
        if ({1'b0, idx} >= (CRAM_AW + 1)'(CRAM_ENTRIES)) begin
            idx = idx - CRAM_AW'(CRAM_ENTRIES);
        end
        return idx;
    endfunction

    assign in_op    = bus_op_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE) && !vram_busy;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign exec_go  = (state_reg == ST_EXEC) && out_free;
    assign cfg_ready = 1'b1;

    // reads issued in the accept cycle, data ready for the update cycle
    assign cmd_vram_rd = (in_op == OP_CTRL_WR) && pending_reg
                         && (s_tdata[7:4] != REG_CMD_TAG) && (s_tdata[7:6] == ACC_VRAM_RD);
    assign dat_vram_rd = (in_op == OP_DATA_RD) && (acc_mode_reg != ACC_CRAM);
    assign vram_rd_en  = accept && (cmd_vram_rd || dat_vram_rd);
    assign rd_addr     = cmd_vram_rd ? {s_tdata[5:0], low_reg} : addr_reg;
    assign vram_rd_idx = vram_index(bank_reg, rd_addr);
    assign vram_wr_en  = exec_go && (op_reg == OP_DATA_WR) && (acc_mode_reg != ACC_CRAM);
    assign vram_wr_idx = vram_index(bank_reg, addr_reg);

    assign cram_idx         = cram_index(addr_reg[CRAM_AW-1:0]);
    assign cram_req.rd_en   = accept && (in_op == OP_DATA_WR) && (acc_mode_reg == ACC_CRAM);
    assign cram_req.rd_idx  = cram_idx;
    assign cram_req.wr_en   = exec_go && (op_reg == OP_DATA_WR) && (acc_mode_reg == ACC_CRAM);
    assign cram_req.wr_idx  = cram_idx;
    assign cram_req.wr_data = byte_reg;

    vcp_vram #(
        .VRAM_BANKS (VRAM_BANKS),
        .BANK_BYTES (BANK_BYTES)
    ) u_vram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (vram_rd_en),
        .rd_idx  (vram_rd_idx),
        .wr_en   (vram_wr_en),
        .wr_idx  (vram_wr_idx),
        .wr_data (byte_reg),
        .rd_data (vram_rdata),
        .busy    (vram_busy)
    );

    vcp_cram #(
        .CRAM_ENTRIES (CRAM_ENTRIES)
    ) u_cram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cram_req),
        .rd_data (cram_rdata)
    );

    assign cmd_addr = {byte_reg[5:0], low_reg};

    always_comb begin
        pending_next  = pending_reg;
        low_next      = low_reg;
        acc_mode_next = acc_mode_reg;
        addr_next     = addr_reg;
        rbuf_next     = rbuf_reg;
        frame_next    = frame_reg;
        line_next     = line_reg;
        res_read      = 8'd0;
        res_pal_chg   = 1'b0;
        res_pal_idx   = '0;
        res_pal_col   = 6'd0;
        res_reg_wr    = 1'b0;
        res_reg_idx   = 4'd0;
        res_reg_val   = 8'd0;
        unique case (op_reg)
            OP_CTRL_WR: begin
                if (!pending_reg) begin
                    pending_next = 1'b1;
                    low_next     = byte_reg;
                end else begin
                    pending_next = 1'b0;
                    if (byte_reg[7:4] == REG_CMD_TAG) begin
                        // display register write; numbers past the last are dropped
                        if (byte_reg[3:0] < NUM_DISP_REGS) begin
                            res_reg_wr  = 1'b1;
                            res_reg_idx = byte_reg[3:0];
                            res_reg_val = low_reg;
                        end
                    end else begin
                        acc_mode_next = byte_reg[7:6];
                        if (byte_reg[7:6] == ACC_CRAM) begin
                            addr_next = {{(ADDR_W - CRAM_AW){1'b0}}, low_reg[CRAM_AW-1:0]};
                        end else if (byte_reg[7:6] == ACC_VRAM_RD) begin
                            rbuf_next = vram_rdata;
                            addr_next = cmd_addr + 1'b1;
                        end else begin
                            addr_next = cmd_addr;
                        end
                    end
                end
            end
            OP_DATA_WR: begin
                pending_next = 1'b0;
                if (acc_mode_reg == ACC_CRAM) begin
                    if (cram_rdata != byte_reg) begin
                        res_pal_chg = 1'b1;
                        res_pal_idx = cram_idx;
                        res_pal_col = byte_reg[5:0];
                    end
                    addr_next = {{(ADDR_W - CRAM_AW){1'b0}},
                                 addr_reg[CRAM_AW-1:0] + 1'b1};
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            OP_STATUS_RD: begin
                res_read   = {frame_reg, line_reg, 6'd0};
                frame_next = 1'b0;
                line_next  = 1'b0;
            end
            OP_DATA_RD: begin
                pending_next = 1'b0;
                res_read     = rbuf_reg;
                if (acc_mode_reg != ACC_CRAM) begin
                    rbuf_next = vram_rdata;
                    addr_next = addr_reg + 1'b1;
                end
            end
            OP_FRAME_IRQ: frame_next = 1'b1;
            OP_LINE_IRQ:  line_next  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bank_reg     <= 1'b0;
            pending_reg  <= 1'b0;
            low_reg      <= 8'd0;
            acc_mode_reg <= 2'd0;
            addr_reg     <= '0;
            rbuf_reg     <= 8'd0;
            frame_reg    <= 1'b0;
            line_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                bank_reg <= cfg_data;
            end
            if (exec_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        op_reg    <= in_op;
                        byte_reg  <= s_tdata;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        pending_reg  <= pending_next;
                        low_reg      <= low_next;
                        acc_mode_reg <= acc_mode_next;
                        addr_reg     <= addr_next;
                        rbuf_reg     <= rbuf_next;
                        frame_reg    <= frame_next;
                        line_reg     <= line_next;
                        m_data_reg   <= {1'b0, res_reg_val, res_reg_idx, res_pal_col,
                                         res_pal_idx, res_read};
                        m_user_reg   <= {res_reg_wr, res_pal_chg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_no_accept_during_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !vram_busy)
        else $error("item accepted while video memory is being cleared");

    a_accept_then_update: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EXEC) && !s_tready)
        else $error("accepted item did not enter the update cycle");

    a_single_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("palette and register update reported by one item");

    a_port_split: assert property (@(posedge aclk) disable iff (!aresetn)
        vram_wr_en |-> !vram_rd_en && !cram_req.rd_en)
        else $error("memory write overlaps a read of the next item");

endmodule
